>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dll_pkg.sv
// Types, constants and the microcode table of the link table block.
// No dependencies; used by the interfaces and every module.
package dll_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MEM_DEPTH = MAX_NODES + 1;
  localparam int ID_W      = $clog2(MAX_NODES + 1);
  localparam int KIND_W    = 2;
  localparam int STEP_W    = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_REMOVE     = 2'd0,
    KIND_INS_BEFORE = 2'd1,
    KIND_INS_AFTER  = 2'd2,
    KIND_QUERY      = 2'd3
  } kind_t;

  // Address and data sources of a link write.
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_A,
    SRC_B,
    SRC_P,
    SRC_N,
    SRC_CLR
  } src_t;

  // How the step counter moves after the current step.
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_END,
    JMP_DISPATCH,
    JMP_CLEAR,
    JMP_EMIT
  } jump_t;

  typedef struct packed {
    jump_t jmp;
    logic  nx_we;
    src_t  nx_addr;
    src_t  nx_data;
    logic  pv_we;
    src_t  pv_addr;
    src_t  pv_data;
    logic  emit;
  } ucode_t;

  // Sequencer to datapath control.
  typedef struct packed {
    logic            accept;
    logic            rd_en;
    ucode_t          uw;
    logic [ID_W-1:0] clr_addr;
    logic            clearing;
  } dll_ctl_t;

  localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_QUERY = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_REM1  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_REM2  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_INSB1 = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_INSB2 = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_INSA1 = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_INSA2 = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_CLEAR = STEP_W'(8);

  // Control store. Writes to link id zero are dropped by the datapath.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    uw = '{jmp: JMP_END, nx_we: 1'b0, nx_addr: SRC_ZERO, nx_data: SRC_ZERO,
           pv_we: 1'b0, pv_addr: SRC_ZERO, pv_data: SRC_ZERO, emit: 1'b0};
    unique case (step)
      STEP_IDLE: uw.jmp = JMP_DISPATCH;
      STEP_QUERY: begin
        uw.jmp  = JMP_EMIT;
        uw.emit = 1'b1;
      end
      STEP_REM1: begin
        uw.jmp = JMP_NEXT;
        uw.nx_we = 1'b1; uw.nx_addr = SRC_P; uw.nx_data = SRC_N;
        uw.pv_we = 1'b1; uw.pv_addr = SRC_N; uw.pv_data = SRC_P;
      end
      STEP_REM2: begin
        uw.nx_we = 1'b1; uw.nx_addr = SRC_A; uw.nx_data = SRC_ZERO;
        uw.pv_we = 1'b1; uw.pv_addr = SRC_A; uw.pv_data = SRC_ZERO;
      end
      STEP_INSB1: begin
        uw.jmp = JMP_NEXT;
        uw.nx_we = 1'b1; uw.nx_addr = SRC_P; uw.nx_data = SRC_B;
        uw.pv_we = 1'b1; uw.pv_addr = SRC_B; uw.pv_data = SRC_P;
      end
      STEP_INSB2: begin
        uw.nx_we = 1'b1; uw.nx_addr = SRC_B; uw.nx_data = SRC_A;
        uw.pv_we = 1'b1; uw.pv_addr = SRC_A; uw.pv_data = SRC_B;
      end
      STEP_INSA1: begin
        uw.jmp = JMP_NEXT;
        uw.nx_we = 1'b1; uw.nx_addr = SRC_B; uw.nx_data = SRC_N;
        uw.pv_we = 1'b1; uw.pv_addr = SRC_N; uw.pv_data = SRC_B;
      end
      STEP_INSA2: begin
        uw.nx_we = 1'b1; uw.nx_addr = SRC_A; uw.nx_data = SRC_B;
        uw.pv_we = 1'b1; uw.pv_addr = SRC_B; uw.pv_data = SRC_A;
      end
      STEP_CLEAR: begin
        uw.jmp = JMP_CLEAR;
        uw.nx_we = 1'b1; uw.nx_addr = SRC_CLR; uw.nx_data = SRC_ZERO;
        uw.pv_we = 1'b1; uw.pv_addr = SRC_CLR; uw.pv_data = SRC_ZERO;
      end
      default: uw.jmp = JMP_END;
    endcase
    return uw;
  endfunction

endpackage

>>> rtl/dll_ifs.sv
// Valid/ready channel interfaces for the link table block.
// Depends on dll_pkg for the id and kind widths.
interface dll_in_if;
  logic                         valid;
  logic                         ready;
  logic [dll_pkg::KIND_W-1:0]   kind;
  logic [dll_pkg::ID_W-1:0]     node_a;
  logic [dll_pkg::ID_W-1:0]     node_b;

  modport source (output valid, kind, node_a, node_b, input ready);
  modport sink   (input valid, kind, node_a, node_b, output ready);
endinterface

interface dll_out_if;
  logic                         valid;
  logic                         ready;
  logic [dll_pkg::ID_W-1:0]     prev_id;
  logic [dll_pkg::ID_W-1:0]     next_id;

  modport source (output valid, prev_id, next_id, input ready);
  modport sink   (input valid, prev_id, next_id, output ready);
endinterface

>>> rtl/doubly_linked_list_table.sv
// Top level of the doubly linked list link table.
// Depends on dll_pkg, dll_ifs, dll_seq, dll_dp and assert_macros.svh.
//
//  channel   dir  payload                      transfer
//  in_chan   in   kind, node_a, node_b         valid && ready
//  out_chan  out  prev_id, next_id             valid && ready (queries only)
//
// Query: transfer in, then load of the result register; it waits
//   in its second step while the result register still holds an untaken result.
// Remove and inserts: transfer with link read, then two write steps, one
//   write per link memory each. Items that change nothing end at the transfer.
// The single read port and write port of each link memory set these steps.
// After reset a clearing pass zeroes ids 1..1024; ready stays low meanwhile.
// A result waiting on out_chan does not stop the next item from being taken.
`include "assert_macros.svh"

module doubly_linked_list_table (
  input  logic        clk,
  input  logic        rst_n,
  dll_in_if.sink      in_chan,
  dll_out_if.source   out_chan
);

  dll_pkg::dll_ctl_t ctl;
  logic              out_free;

  // Step counter and control store; drive the datapath one control word a cycle.
  dll_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_kind   (in_chan.kind),
    .in_node_a (in_chan.node_a),
    .in_node_b (in_chan.node_b),
    .out_free  (out_free),
    .in_ready  (in_chan.ready),
    .ctl       (ctl)
  );

  // Link memories and the result register that parts the two channels.
  dll_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_node_a   (in_chan.node_a),
    .in_node_b   (in_chan.node_b),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_prev_id (out_chan.prev_id),
    .out_next_id (out_chan.next_id),
    .out_free    (out_free)
  );

  // Hold off input during the clearing pass.
  `ASSERT_SAME(a_no_accept_clearing, ctl.clearing, !in_chan.ready, "item taken while clearing")
  // A query transfer is always followed by a busy cycle.
  `ASSERT_NEXT(a_one_at_a_time, in_chan.valid && in_chan.ready && in_chan.kind == dll_pkg::KIND_QUERY,
               !in_chan.ready, "input ready straight after a query transfer")
  // A result load always shows up on the output the next cycle.
  `ASSERT_NEXT(a_emit_shows, ctl.uw.emit && out_free, out_chan.valid,
               "query result lost")

endmodule

>>> rtl/dll_seq.sv
// Microcode sequencer: step counter, control store fetch, dispatch and clear counter.
// Depends on dll_pkg.
module dll_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [dll_pkg::KIND_W-1:0]   in_kind,
  input  logic [dll_pkg::ID_W-1:0]     in_node_a,
  input  logic [dll_pkg::ID_W-1:0]     in_node_b,
  input  logic                         out_free,
  output logic                         in_ready,
  output dll_pkg::dll_ctl_t            ctl
);

  logic [dll_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [dll_pkg::ID_W-1:0]   clr_r, clr_nxt;
  dll_pkg::ucode_t            uw;
  dll_pkg::kind_t             kind;
  logic                       a_ok, b_ok, accept;
  logic [dll_pkg::STEP_W-1:0] target;

  assign uw     = dll_pkg::ucode_rom(step_r);
  assign kind   = dll_pkg::kind_t'(in_kind);
  assign a_ok   = (in_node_a != '0) && (in_node_a <= dll_pkg::ID_W'(dll_pkg::MAX_NODES));
  assign b_ok   = in_node_b <= dll_pkg::ID_W'(dll_pkg::MAX_NODES);
  assign in_ready = (step_r == dll_pkg::STEP_IDLE);
  assign accept = in_valid && in_ready;

  // Dispatch target; drop items that would do nothing.
  always_comb begin
    priority if (kind == dll_pkg::KIND_QUERY) target = dll_pkg::STEP_QUERY;
    else if (!a_ok)                          target = dll_pkg::STEP_IDLE;
    else if (kind == dll_pkg::KIND_REMOVE)   target = dll_pkg::STEP_REM1;
    else if (!b_ok)                          target = dll_pkg::STEP_IDLE;
    else if (kind == dll_pkg::KIND_INS_BEFORE) target = dll_pkg::STEP_INSB1;
    else                                     target = dll_pkg::STEP_INSA1;
  end

  always_comb begin
    step_nxt = step_r;
    clr_nxt  = clr_r;
    unique case (uw.jmp)
      dll_pkg::JMP_NEXT:     step_nxt = step_r + dll_pkg::STEP_W'(1);
      dll_pkg::JMP_END:      step_nxt = dll_pkg::STEP_IDLE;
      dll_pkg::JMP_DISPATCH: if (accept) step_nxt = target;
      dll_pkg::JMP_CLEAR: begin
        clr_nxt = clr_r + dll_pkg::ID_W'(1);
        if (clr_r == dll_pkg::ID_W'(dll_pkg::MAX_NODES)) step_nxt = dll_pkg::STEP_IDLE;
      end
      dll_pkg::JMP_EMIT:     if (out_free) step_nxt = dll_pkg::STEP_IDLE;
      default:               step_nxt = dll_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dll_pkg::STEP_CLEAR;
      clr_r  <= dll_pkg::ID_W'(1);
    end else begin
      step_r <= step_nxt;
      clr_r  <= clr_nxt;
    end
  end

  assign ctl.accept   = accept;
  assign ctl.rd_en    = accept && a_ok;
  assign ctl.uw       = uw;
  assign ctl.clr_addr = clr_r;
  assign ctl.clearing = (step_r == dll_pkg::STEP_CLEAR);

endmodule

>>> rtl/dll_dp.sv
// Datapath: prev and next link memories, operand registers and the result register.
// Depends on dll_pkg; driven by dll_seq.
module dll_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dll_pkg::dll_ctl_t          ctl,
  input  logic [dll_pkg::ID_W-1:0]   in_node_a,
  input  logic [dll_pkg::ID_W-1:0]   in_node_b,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [dll_pkg::ID_W-1:0]   out_prev_id,
  output logic [dll_pkg::ID_W-1:0]   out_next_id,
  output logic                       out_free
);

  logic [dll_pkg::ID_W-1:0] prev_mem [dll_pkg::MEM_DEPTH];
  logic [dll_pkg::ID_W-1:0] next_mem [dll_pkg::MEM_DEPTH];

  logic [dll_pkg::ID_W-1:0] a_r, b_r, p_r, n_r;
  logic                     a_ok_r;
  logic                     out_valid_r;
  logic [dll_pkg::ID_W-1:0] out_prev_r, out_next_r;

  logic [dll_pkg::ID_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
  logic                     nx_wr, pv_wr, load_out;

  function automatic logic [dll_pkg::ID_W-1:0] pick(
    input dll_pkg::src_t src, input logic [dll_pkg::ID_W-1:0] a,
    input logic [dll_pkg::ID_W-1:0] b, input logic [dll_pkg::ID_W-1:0] p,
    input logic [dll_pkg::ID_W-1:0] n, input logic [dll_pkg::ID_W-1:0] c);
    logic [dll_pkg::ID_W-1:0] v;
    unique case (src)
      dll_pkg::SRC_A:   v = a;
      dll_pkg::SRC_B:   v = b;
      dll_pkg::SRC_P:   v = p;
      dll_pkg::SRC_N:   v = n;
      dll_pkg::SRC_CLR: v = c;
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign nx_wa = pick(ctl.uw.nx_addr, a_r, b_r, p_r, n_r, ctl.clr_addr);
  assign nx_wd = pick(ctl.uw.nx_data, a_r, b_r, p_r, n_r, ctl.clr_addr);
  assign pv_wa = pick(ctl.uw.pv_addr, a_r, b_r, p_r, n_r, ctl.clr_addr);
  assign pv_wd = pick(ctl.uw.pv_data, a_r, b_r, p_r, n_r, ctl.clr_addr);
  // Drop any write aimed at link id zero.
  assign nx_wr = ctl.uw.nx_we && (nx_wa != '0);
  assign pv_wr = ctl.uw.pv_we && (pv_wa != '0);

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      a_r    <= in_node_a;
      b_r    <= in_node_b;
      a_ok_r <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (pv_wr) prev_mem[pv_wa] <= pv_wd;
    if (ctl.rd_en) p_r <= prev_mem[in_node_a];
  end

  always_ff @(posedge clk) begin
    if (nx_wr) next_mem[nx_wa] <= nx_wd;
    if (ctl.rd_en) n_r <= next_mem[in_node_a];
  end

  assign out_free = !out_valid_r || out_ready;
  assign load_out = ctl.uw.emit && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_prev_r <= a_ok_r ? p_r : '0;
      out_next_r <= a_ok_r ? n_r : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_prev_id = out_prev_r;
  assign out_next_id = out_next_r;

endmodule
